>>> hw/rtl/mbr_pkg.sv
// -----------------------------------------------------------------------------
// mbr_pkg
// Shared types and constants of the masked bilinear remap block.
// -----------------------------------------------------------------------------
package mbr_pkg;

   // field widths fixed by the request and response formats
   localparam int COORD_W    = 19;
   localparam int LOAD_COL_W = 10;
   localparam int LOAD_ROW_W = 10;
   localparam int PIX_W      = 8;
   localparam int ENTRY_W    = PIX_W + 1;   // {mask bit, pixel}
   localparam int CFG_W      = 11;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 16;

   // defaults of the top-level parameters
   localparam int MAX_COLUMNS_DEF   = 1024;
   localparam int MAX_ROWS_DEF      = 1024;
   localparam int FRACTION_BITS_DEF = 8;

   // configuration reset values
   localparam logic [CFG_W-1:0] SOURCE_WIDTH_RST  = 11'd640;
   localparam logic [CFG_W-1:0] SOURCE_HEIGHT_RST = 11'd480;

   typedef enum logic [0:0] {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      CSR_SOURCE_WIDTH  = 1'b0,
      CSR_SOURCE_HEIGHT = 1'b1
   } csr_index_type;

   // per-request control flags handed from stage to stage
   // ok: load inside the store, or query passing the enable and range checks
   typedef struct packed {
      logic is_query;
      logic ok;
      logic right;
      logic down;
   } mbr_ctl_type;

endpackage

>>> hw/rtl/mbr_ram.sv
// -----------------------------------------------------------------------------
// mbr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// -----------------------------------------------------------------------------
module mbr_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/mbr_decode.sv
// -----------------------------------------------------------------------------
// mbr_decode
// First stage: range checks, split of the coordinates into integer and
// fraction parts, edge flags, and load address check.
// -----------------------------------------------------------------------------
module mbr_decode #(
   parameter int MAX_COLUMNS   = mbr_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS      = mbr_pkg::MAX_ROWS_DEF,
   parameter int FRACTION_BITS = mbr_pkg::FRACTION_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  mbr_pkg::op_type                     operation,
   input  logic [mbr_pkg::LOAD_COL_W-1:0]      load_column,
   input  logic [mbr_pkg::LOAD_ROW_W-1:0]      load_row,
   input  logic [mbr_pkg::PIX_W-1:0]           load_pixel,
   input  logic                                load_valid,
   input  logic signed [mbr_pkg::COORD_W-1:0]  coord_u,
   input  logic signed [mbr_pkg::COORD_W-1:0]  coord_v,
   input  logic                                query_enable,
   input  logic [mbr_pkg::CFG_W-1:0]           source_width,
   input  logic [mbr_pkg::CFG_W-1:0]           source_height,
   output logic                                out_valid,
   input  logic                                out_ready,
   output mbr_pkg::mbr_ctl_type                out_ctl,
   output logic [$clog2(MAX_COLUMNS)-1:0]      out_col,
   output logic [$clog2(MAX_ROWS)-1:0]         out_row,
   output logic [FRACTION_BITS-1:0]            out_du,
   output logic [FRACTION_BITS-1:0]            out_dv,
   output logic [mbr_pkg::ENTRY_W-1:0]         out_entry
);
   import mbr_pkg::*;

   localparam int FB   = FRACTION_BITS;
   localparam int CW   = $clog2(MAX_COLUMNS);
   localparam int RW   = $clog2(MAX_ROWS);
   localparam int CWW  = $clog2(MAX_COLUMNS + 1);
   localparam int RWW  = $clog2(MAX_ROWS + 1);
   localparam int MAGW = COORD_W - 1;
   localparam int IW   = MAGW - FB;
   localparam int LCW  = (CWW > LOAD_COL_W) ? CWW : LOAD_COL_W;
   localparam int LRW  = (RWW > LOAD_ROW_W) ? RWW : LOAD_ROW_W;
   localparam int XCW  = (CWW > CFG_W) ? CWW : CFG_W;
   localparam int XRW  = (RWW > CFG_W) ? RWW : CFG_W;
   localparam int LWU  = (CWW + FB > MAGW) ? CWW + FB : MAGW;
   localparam int LWV  = (RWW + FB > MAGW) ? RWW + FB : MAGW;
   localparam int KCW  = (CWW > IW) ? CWW : IW;
   localparam int KRW  = (RWW > IW) ? RWW : IW;

   // saturated image size
   logic [XCW-1:0] wx, wx_sat;
   logic [XRW-1:0] hx, hx_sat;
   logic [CWW-1:0] w_lim, w_m1;
   logic [RWW-1:0] h_lim, h_m1;
   logic           size_bad;

   // coordinate split
   logic [MAGW-1:0] u_mag, v_mag;
   logic [IW-1:0]   ui, vi;
   logic [KCW-1:0]  ui_k;
   logic [KRW-1:0]  vi_k;
   logic            u_over, v_over, q_ok;

   // load address
   logic [LCW-1:0] lc_ext;
   logic [LRW-1:0] lr_ext;
   logic           ld_ok;

   // next values and registers
   mbr_ctl_type           ctl_in, ctl_ff;
   logic [CW-1:0]         col_in, col_ff;
   logic [RW-1:0]         row_in, row_ff;
   logic [FB-1:0]         du_in, du_ff, dv_in, dv_ff;
   logic [ENTRY_W-1:0]    entry_ff;
   logic                  v_ff;

   always_comb begin
      wx     = XCW'(source_width);
      hx     = XRW'(source_height);
      wx_sat = (wx > XCW'(MAX_COLUMNS)) ? XCW'(MAX_COLUMNS) : wx;
      hx_sat = (hx > XRW'(MAX_ROWS)) ? XRW'(MAX_ROWS) : hx;
      w_lim  = wx_sat[CWW-1:0];
      h_lim  = hx_sat[RWW-1:0];
      w_m1   = w_lim - CWW'(1);
      h_m1   = h_lim - RWW'(1);
      size_bad = (w_lim == '0) || (h_lim == '0);

      u_mag  = coord_u[MAGW-1:0];
      v_mag  = coord_v[MAGW-1:0];
      ui     = u_mag[MAGW-1:FB];
      vi     = v_mag[MAGW-1:FB];
      ui_k   = KCW'(ui);
      vi_k   = KRW'(vi);
      u_over = LWU'(u_mag) > LWU'({w_m1, {FB{1'b0}}});
      v_over = LWV'(v_mag) > LWV'({h_m1, {FB{1'b0}}});
      q_ok   = query_enable && !size_bad && !coord_u[MAGW] && !coord_v[MAGW] &&
               !u_over && !v_over;

      lc_ext = LCW'(load_column);
      lr_ext = LRW'(load_row);
      ld_ok  = (lc_ext < LCW'(MAX_COLUMNS)) && (lr_ext < LRW'(MAX_ROWS));

      ctl_in.is_query = (operation == OP_QUERY);
      ctl_in.ok       = ctl_in.is_query ? q_ok : ld_ok;
      ctl_in.right    = ui_k != KCW'(w_m1);
      ctl_in.down     = vi_k != KRW'(h_m1);
      col_in = ctl_in.is_query ? ui_k[CW-1:0] : lc_ext[CW-1:0];
      row_in = ctl_in.is_query ? vi_k[RW-1:0] : lr_ext[RW-1:0];
      du_in  = u_mag[FB-1:0];
      dv_in  = v_mag[FB-1:0];
   end

   assign in_ready = !v_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         ctl_ff   <= ctl_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         du_ff    <= du_in;
         dv_ff    <= dv_in;
         entry_ff <= {load_valid, load_pixel};
      end
   end

   assign out_valid = v_ff;
   assign out_ctl   = ctl_ff;
   assign out_col   = col_ff;
   assign out_row   = row_ff;
   assign out_du    = du_ff;
   assign out_dv    = dv_ff;
   assign out_entry = entry_ff;

`ifndef NO_ASSERTIONS
   // a query on the last column must carry no horizontal fraction
   a_last_col_no_frac: assert property (@(posedge clock) disable iff (reset)
      v_ff && ctl_ff.is_query && ctl_ff.ok && !ctl_ff.right |-> du_ff == '0)
      else $error("query on last column with nonzero fraction");

   // same for the last row
   a_last_row_no_frac: assert property (@(posedge clock) disable iff (reset)
      v_ff && ctl_ff.is_query && ctl_ff.ok && !ctl_ff.down |-> dv_ff == '0)
      else $error("query on last row with nonzero fraction");
`endif

endmodule

>>> hw/rtl/mbr_fetch.sv
// -----------------------------------------------------------------------------
// mbr_fetch
// Second stage: parity-banked pixel store. Loads write one bank; queries read
// the four neighbors, one from each bank, and compute the bilinear weights.
// -----------------------------------------------------------------------------
module mbr_fetch #(
   parameter int MAX_COLUMNS   = mbr_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS      = mbr_pkg::MAX_ROWS_DEF,
   parameter int FRACTION_BITS = mbr_pkg::FRACTION_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  mbr_pkg::mbr_ctl_type             in_ctl,
   input  logic [$clog2(MAX_COLUMNS)-1:0]   in_col,
   input  logic [$clog2(MAX_ROWS)-1:0]      in_row,
   input  logic [FRACTION_BITS-1:0]         in_du,
   input  logic [FRACTION_BITS-1:0]         in_dv,
   input  logic [mbr_pkg::ENTRY_W-1:0]      in_entry,
   output logic                             out_valid,
   input  logic                             out_ready,
   output mbr_pkg::mbr_ctl_type             out_ctl,
   output logic [mbr_pkg::ENTRY_W-1:0]      out_e00,
   output logic [mbr_pkg::ENTRY_W-1:0]      out_e01,
   output logic [mbr_pkg::ENTRY_W-1:0]      out_e10,
   output logic [mbr_pkg::ENTRY_W-1:0]      out_e11,
   output logic [2*FRACTION_BITS:0]         out_w00,
   output logic [2*FRACTION_BITS:0]         out_w01,
   output logic [2*FRACTION_BITS:0]         out_w10,
   output logic [2*FRACTION_BITS:0]         out_w11
);
   import mbr_pkg::*;

   localparam int FB    = FRACTION_BITS;
   localparam int CW    = $clog2(MAX_COLUMNS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int CHW   = (CW > 1) ? CW - 1 : 1;
   localparam int RHW   = (RW > 1) ? RW - 1 : 1;
   localparam int AW    = CHW + RHW;
   localparam int BANK_DEPTH = 2 ** AW;
   localparam int WW    = 2 * FB + 1;
   localparam int PW    = 2 * FB + 2;

   logic [CW-1:0]       c1;
   logic [RW-1:0]       r1;
   logic [3:0]          bank_we;
   logic [AW-1:0]       bank_addr [4];
   logic [ENTRY_W-1:0]  rd_data [4];
   logic                adv;

   logic [FB:0]         a0, a1, b0, b1;
   logic [PW-1:0]       p00, p01, p10, p11;

   logic                v_ff;
   mbr_ctl_type         ctl_ff;
   logic                rpar_ff, cpar_ff;
   logic [WW-1:0]       w00_ff, w01_ff, w10_ff, w11_ff;

   function automatic logic [ENTRY_W-1:0] pick(input logic rp, input logic cp,
                                                input logic [ENTRY_W-1:0] d0,
                                                input logic [ENTRY_W-1:0] d1,
                                                input logic [ENTRY_W-1:0] d2,
                                                input logic [ENTRY_W-1:0] d3);
      logic [ENTRY_W-1:0] r;
      case ({rp, cp})
         2'b00:   r = d0;
         2'b01:   r = d1;
         2'b10:   r = d2;
         default: r = d3;
      endcase
      return r;
   endfunction

   assign adv      = !v_ff || out_ready;
   assign in_ready = adv;

   assign c1 = in_col + CW'(1);
   assign r1 = in_row + RW'(1);

   // bank {p,q} holds rows of parity p and columns of parity q
   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [CW-1:0] col_sel;
      logic [RW-1:0] row_sel;

      assign col_sel = (in_col[0] == b[0]) ? in_col : c1;
      assign row_sel = (in_row[0] == b[1]) ? in_row : r1;
      assign bank_addr[b] = {RHW'(row_sel >> 1), CHW'(col_sel >> 1)};
      assign bank_we[b] = in_valid && adv && !in_ctl.is_query && in_ctl.ok &&
                          (in_row[0] == b[1]) && (in_col[0] == b[0]);

      mbr_ram #(
         .WIDTH (ENTRY_W),
         .DEPTH (BANK_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (bank_we[b]),
         .wr_addr (bank_addr[b]),
         .wr_data (in_entry),
         .rd_en   (adv),
         .rd_addr (bank_addr[b]),
         .rd_data (rd_data[b])
      );
   end

   // weights: (S-du)(S-dv), du(S-dv), (S-du)dv, du dv
   always_comb begin
      a1  = {1'b0, in_du};
      b1  = {1'b0, in_dv};
      a0  = {1'b1, {FB{1'b0}}} - a1;
      b0  = {1'b1, {FB{1'b0}}} - b1;
      p00 = PW'(a0) * PW'(b0);
      p01 = PW'(a1) * PW'(b0);
      p10 = PW'(a0) * PW'(b1);
      p11 = PW'(a1) * PW'(b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (adv) begin
         v_ff <= in_valid && in_ctl.is_query;   // drop loads here
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl_ff  <= in_ctl;
         rpar_ff <= in_row[0];
         cpar_ff <= in_col[0];
         w00_ff  <= p00[WW-1:0];
         w01_ff  <= p01[WW-1:0];
         w10_ff  <= p10[WW-1:0];
         w11_ff  <= p11[WW-1:0];
      end
   end

   assign out_valid = v_ff;
   assign out_ctl   = ctl_ff;
   assign out_e00 = pick(rpar_ff, cpar_ff,
                         rd_data[0], rd_data[1], rd_data[2], rd_data[3]);
   assign out_e01 = pick(rpar_ff, !cpar_ff,
                         rd_data[0], rd_data[1], rd_data[2], rd_data[3]);
   assign out_e10 = pick(!rpar_ff, cpar_ff,
                         rd_data[0], rd_data[1], rd_data[2], rd_data[3]);
   assign out_e11 = pick(!rpar_ff, !cpar_ff,
                         rd_data[0], rd_data[1], rd_data[2], rd_data[3]);
   assign out_w00 = w00_ff;
   assign out_w01 = w01_ff;
   assign out_w10 = w10_ff;
   assign out_w11 = w11_ff;

`ifndef NO_ASSERTIONS
   // a load touches at most one bank, a query none
   a_one_bank_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0(bank_we) && (!(in_valid && in_ctl.is_query) || bank_we == '0))
      else $error("bank write conflict");
`endif

endmodule

>>> hw/rtl/mbr_blend.sv
// -----------------------------------------------------------------------------
// mbr_blend
// Third and fourth stages: mask check and pixel-by-weight products, then the
// rounded sum into the response register.
// -----------------------------------------------------------------------------
module mbr_blend #(
   parameter int FRACTION_BITS = mbr_pkg::FRACTION_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  mbr_pkg::mbr_ctl_type           in_ctl,
   input  logic [mbr_pkg::ENTRY_W-1:0]    in_e00,
   input  logic [mbr_pkg::ENTRY_W-1:0]    in_e01,
   input  logic [mbr_pkg::ENTRY_W-1:0]    in_e10,
   input  logic [mbr_pkg::ENTRY_W-1:0]    in_e11,
   input  logic [2*FRACTION_BITS:0]       in_w00,
   input  logic [2*FRACTION_BITS:0]       in_w01,
   input  logic [2*FRACTION_BITS:0]       in_w10,
   input  logic [2*FRACTION_BITS:0]       in_w11,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [mbr_pkg::PIX_W-1:0]      out_value,
   output logic                           out_flag
);
   import mbr_pkg::*;

   localparam int FB = FRACTION_BITS;
   localparam int WW = 2 * FB + 1;
   localparam int MW = PIX_W + WW;
   localparam int SW = MW + 2;
   localparam int VW = SW - 2 * FB;

   logic               adv3, adv4;
   logic [PIX_W-1:0]   p00, p01, p10, p11;
   logic               ok_in;
   logic [MW-1:0]      m00_in, m01_in, m10_in, m11_in;

   logic               v3_ff, ok3_ff;
   logic [MW-1:0]      m00_ff, m01_ff, m10_ff, m11_ff;

   logic [SW-1:0]      sum;
   logic [VW-1:0]      val_full;
   logic [PIX_W-1:0]   value_in;

   logic               v4_ff, flag_ff;
   logic [PIX_W-1:0]   value_ff;

   assign adv4     = !v4_ff || out_ready;
   assign adv3     = !v3_ff || adv4;
   assign in_ready = adv3;

   // mask neighbors past the edge so that unread entries cannot leak in
   always_comb begin
      p00    = in_e00[PIX_W-1:0];
      p01    = in_ctl.right ? in_e01[PIX_W-1:0] : '0;
      p10    = in_ctl.down ? in_e10[PIX_W-1:0] : '0;
      p11    = (in_ctl.right && in_ctl.down) ? in_e11[PIX_W-1:0] : '0;
      ok_in  = in_ctl.ok && in_e00[PIX_W] &&
               (!in_ctl.right || in_e01[PIX_W]) &&
               (!in_ctl.down || in_e10[PIX_W]) &&
               (!(in_ctl.right && in_ctl.down) || in_e11[PIX_W]);
      m00_in = MW'(p00) * MW'(in_w00);
      m01_in = MW'(p01) * MW'(in_w01);
      m10_in = MW'(p10) * MW'(in_w10);
      m11_in = MW'(p11) * MW'(in_w11);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv3) begin
         v3_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         ok3_ff <= ok_in;
         m00_ff <= m00_in;
         m01_ff <= m01_in;
         m10_ff <= m10_in;
         m11_ff <= m11_in;
      end
   end

   // add half, shift down, clamp; zero when the request is not ok
   always_comb begin
      sum = SW'(m00_ff) + SW'(m01_ff) + SW'(m10_ff) + SW'(m11_ff) +
            (SW'(1) << (2 * FB - 1));
      val_full = sum[SW-1:2*FB];
      if (!ok3_ff) begin
         value_in = '0;
      end else if (|val_full[VW-1:PIX_W]) begin
         value_in = '1;
      end else begin
         value_in = val_full[PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv4) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv4 && v3_ff) begin
         value_ff <= value_in;
         flag_ff  <= ok3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_value = value_ff;
   assign out_flag  = flag_ff;

endmodule

>>> hw/rtl/masked_bilinear_remap_top.sv
// -----------------------------------------------------------------------------
// masked_bilinear_remap_top
// Bilinear remap of a masked 8-bit source image held in a parity-banked store.
// -----------------------------------------------------------------------------
// Usage:
//   req_* carries requests. tuser = operation (load or query). A load writes
//   one source pixel and its mask bit and yields no response. A query gives a
//   fixed-point source coordinate and yields one response on rsp_*: the
//   interpolated pixel and its valid flag (zero and invalid when disabled,
//   out of range, or touching a masked-off neighbor).
//   csr_* writes the source width (index 0) and height (index 1); write only
//   while no request is in flight.
// Timing:
//   Throughput is one request per cycle unless rsp_tready stalls the pipeline.
//   A query passes these registers in turn before rsp_tvalid rises:
//   decode register, bank read register, product register, response register.
//   The four neighbors come from four parity banks in one read, so no request
//   waits on a memory port.
// Reset:
//   Synchronous reset clears the pipeline valid bits and restores the size
//   registers to 640 x 480. The pixel store is not cleared; load every pixel
//   before a query reads it.
// Stall:
//   When rsp_tready is low the response holds and stages fill behind it;
//   req_tready drops only once every stage holds a request.
// -----------------------------------------------------------------------------
module masked_bilinear_remap_top #(
   parameter int MAX_COLUMNS   = mbr_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS      = mbr_pkg::MAX_ROWS_DEF,
   parameter int FRACTION_BITS = mbr_pkg::FRACTION_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [9:0] load_column, [19:10] load_row, [27:20] load_pixel, [28] load_valid,
   // [47:29] coord_u, [66:48] coord_v, [67] query_enable, [71:68] zero
   input  logic [mbr_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] operation
   input  logic [0:0]                        req_tuser,
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] out_value, [8] out_valid, [15:9] zero
   output logic [mbr_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // configuration
   input  logic                              csr_we,
   input  mbr_pkg::csr_index_type            csr_index,
   input  logic [mbr_pkg::CFG_W-1:0]         csr_wdata
);
   import mbr_pkg::*;

   localparam int CW = $clog2(MAX_COLUMNS);
   localparam int RW = $clog2(MAX_ROWS);
   localparam int FB = FRACTION_BITS;

   // size registers
   logic [CFG_W-1:0] width_ff, height_ff;

   // decode -> fetch
   logic                d_valid, d_ready;
   mbr_ctl_type         d_ctl;
   logic [CW-1:0]       d_col;
   logic [RW-1:0]       d_row;
   logic [FB-1:0]       d_du, d_dv;
   logic [ENTRY_W-1:0]  d_entry;

   // fetch -> blend
   logic                f_valid, f_ready;
   mbr_ctl_type         f_ctl;
   logic [ENTRY_W-1:0]  f_e00, f_e01, f_e10, f_e11;
   logic [2*FB:0]       f_w00, f_w01, f_w10, f_w11;

   // response
   logic [PIX_W-1:0]    out_value;
   logic                out_flag;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SOURCE_WIDTH_RST;
         height_ff <= SOURCE_HEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SOURCE_WIDTH:  width_ff  <= csr_wdata;
            CSR_SOURCE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // unpack the request and check ranges
   mbr_decode #(
      .MAX_COLUMNS   (MAX_COLUMNS),
      .MAX_ROWS      (MAX_ROWS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_decode (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .operation     (op_type'(req_tuser[0])),
      .load_column   (req_tdata[9:0]),
      .load_row      (req_tdata[19:10]),
      .load_pixel    (req_tdata[27:20]),
      .load_valid    (req_tdata[28]),
      .coord_u       (req_tdata[47:29]),
      .coord_v       (req_tdata[66:48]),
      .query_enable  (req_tdata[67]),
      .source_width  (width_ff),
      .source_height (height_ff),
      .out_valid     (d_valid),
      .out_ready     (d_ready),
      .out_ctl       (d_ctl),
      .out_col       (d_col),
      .out_row       (d_row),
      .out_du        (d_du),
      .out_dv        (d_dv),
      .out_entry     (d_entry)
   );

   // write loads, read the four neighbors of queries
   mbr_fetch #(
      .MAX_COLUMNS   (MAX_COLUMNS),
      .MAX_ROWS      (MAX_ROWS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_fetch (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid),
      .in_ready  (d_ready),
      .in_ctl    (d_ctl),
      .in_col    (d_col),
      .in_row    (d_row),
      .in_du     (d_du),
      .in_dv     (d_dv),
      .in_entry  (d_entry),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_ctl   (f_ctl),
      .out_e00   (f_e00),
      .out_e01   (f_e01),
      .out_e10   (f_e10),
      .out_e11   (f_e11),
      .out_w00   (f_w00),
      .out_w01   (f_w01),
      .out_w10   (f_w10),
      .out_w11   (f_w11)
   );

   // weight, sum, round
   mbr_blend #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_ctl    (f_ctl),
      .in_e00    (f_e00),
      .in_e01    (f_e01),
      .in_e10    (f_e10),
      .in_e11    (f_e11),
      .in_w00    (f_w00),
      .in_w01    (f_w01),
      .in_w10    (f_w10),
      .in_w11    (f_w11),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_value (out_value),
      .out_flag  (out_flag)
   );

   assign rsp_tdata = {{(RSP_DATA_W - PIX_W - 1){1'b0}}, out_flag, out_value};

`ifndef NO_ASSERTIONS
   // an invalid response always carries a zero pixel
   a_invalid_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[PIX_W] || rsp_tdata[PIX_W-1:0] == '0)
      else $error("invalid response with nonzero pixel");

   // no response straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");
`endif

endmodule

>>> tb/mbr_checker.sv
// -----------------------------------------------------------------------------
// mbr_checker
// Watches the request, response and csr ports of the masked bilinear remap
// block, predicts each query response from its own image store and size
// registers, and compares every response with the oldest prediction.
// -----------------------------------------------------------------------------
module mbr_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // [9:0] load_column, [19:10] load_row, [27:20] load_pixel, [28] load_valid,
   // [47:29] coord_u, [66:48] coord_v, [67] query_enable, [71:68] zero
   input  logic [mbr_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] operation
   input  logic [0:0]                     req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [7:0] out_value, [8] out_valid, [15:9] zero
   input  logic [mbr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_we,
   input  mbr_pkg::csr_index_type         csr_index,
   input  logic [mbr_pkg::CFG_W-1:0]      csr_wdata,
   output int                             fail_count,
   output int                             pending
);
   import mbr_pkg::*;

   localparam int     STORE_DEPTH = MAX_COLUMNS_DEF * MAX_ROWS_DEF;
   localparam int     FRAC        = FRACTION_BITS_DEF;
   localparam longint ONE         = longint'(1) << FRAC;

   // {mask bit, pixel}, addressed row * MAX_COLUMNS + column
   bit   [ENTRY_W-1:0] image_mem [STORE_DEPTH];
   int                 size_w;
   int                 size_h;
   logic [ENTRY_W-1:0] pixels_due [$];

   function automatic logic [ENTRY_W-1:0] remap_pixel(input logic [COORD_W-1:0] u_raw,
                                                       input logic [COORD_W-1:0] v_raw,
                                                       input logic en);
      longint u, v, wsz, hsz, du, dv, acc;
      int     ui, vi;
      bit     right, down;
      logic [ENTRY_W-1:0] p00, p01, p10, p11;
      wsz = (size_w > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : size_w;
      hsz = (size_h > MAX_ROWS_DEF) ? MAX_ROWS_DEF : size_h;
      u   = longint'($signed(u_raw));
      v   = longint'($signed(v_raw));
      if (!en || wsz == 0 || hsz == 0 || u < 0 || v < 0) return '0;
      if (u > ((wsz - 1) << FRAC) || v > ((hsz - 1) << FRAC)) return '0;
      ui    = int'(u >> FRAC);
      vi    = int'(v >> FRAC);
      du    = u & (ONE - 1);
      dv    = v & (ONE - 1);
      right = (ui != wsz - 1);
      down  = (vi != hsz - 1);
      // skip neighbors past the right or bottom edge entirely
      p00 = image_mem[vi * MAX_COLUMNS_DEF + ui];
      p01 = right ? image_mem[vi * MAX_COLUMNS_DEF + ui + 1] : '0;
      p10 = down ? image_mem[(vi + 1) * MAX_COLUMNS_DEF + ui] : '0;
      p11 = (right && down) ? image_mem[(vi + 1) * MAX_COLUMNS_DEF + ui + 1] : '0;
      if (!p00[PIX_W] || (right && !p01[PIX_W]) || (down && !p10[PIX_W]) ||
          (right && down && !p11[PIX_W])) return '0;
      acc = longint'(p00[PIX_W-1:0]) * (ONE - du) * (ONE - dv)
          + longint'(p01[PIX_W-1:0]) * du * (ONE - dv)
          + longint'(p10[PIX_W-1:0]) * (ONE - du) * dv
          + longint'(p11[PIX_W-1:0]) * du * dv;
      // round half up
      acc = (acc + ONE * ONE / 2) >> (2 * FRAC);
      if (acc > 255) acc = 255;
      return {1'b1, acc[PIX_W-1:0]};
   endfunction

   always @(posedge clock) begin
      logic [ENTRY_W-1:0] want;
      int                 col, row;
      if (reset) begin
         size_w = SOURCE_WIDTH_RST;
         size_h = SOURCE_HEIGHT_RST;
         pixels_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SOURCE_WIDTH:  size_w = csr_wdata;
               CSR_SOURCE_HEIGHT: size_h = csr_wdata;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pixels_due.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response: expected none, got value %0d valid %0b",
                        $time, rsp_tdata[PIX_W-1:0], rsp_tdata[PIX_W]);
            end else begin
               want = pixels_due.pop_front();
               if (rsp_tdata[PIX_W-1:0] !== want[PIX_W-1:0] ||
                   rsp_tdata[PIX_W] !== want[PIX_W]) begin
                  fail_count++;
                  $display("%0t: response mismatch: expected value %0d valid %0b, got value %0d valid %0b",
                           $time, want[PIX_W-1:0], want[PIX_W],
                           rsp_tdata[PIX_W-1:0], rsp_tdata[PIX_W]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_LOAD) begin
               col = int'(req_tdata[9:0]);
               row = int'(req_tdata[19:10]);
               if (col < MAX_COLUMNS_DEF && row < MAX_ROWS_DEF)
                  image_mem[row * MAX_COLUMNS_DEF + col] = {req_tdata[28], req_tdata[27:20]};
            end else begin
               pixels_due.push_back(remap_pixel(req_tdata[47:29], req_tdata[66:48],
                                                req_tdata[67]));
            end
         end
      end
      pending = pixels_due.size();
   end

endmodule

>>> tb/testbench.sv
// -----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the masked bilinear remap block. A directed pass
// covers the reset size, range edges, skipped and masked neighbors and
// rounding; random passes then sweep the size registers while loading the
// neighbors of each query before it is issued. The checker predicts and
// compares; this module only drives and decides.
// -----------------------------------------------------------------------------
module testbench;
   import mbr_pkg::*;

   localparam int GRID_COLS    = MAX_COLUMNS_DEF;
   localparam int GRID_ROWS    = MAX_ROWS_DEF;
   localparam int FRAC         = FRACTION_BITS_DEF;
   localparam int ONE          = 1 << FRAC;
   localparam int RANDOM_ITEMS = 400;
   localparam int PHASES       = 9;
   localparam int DRAIN_CYCLES = 10;    // pipeline is four deep, loads leave no response
   localparam int HOLD_CYCLES  = 100;   // long response back-pressure stretch
   localparam int STALL_LIMIT  = 2000;  // cycles without any handshake

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata   = '0;
   logic [0:0]              req_tuser   = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_we      = 1'b0;
   csr_index_type           csr_index   = CSR_SOURCE_WIDTH;
   logic [CFG_W-1:0]        csr_wdata   = '0;

   int fail_count;
   int pending;

   // idle rates in percent, switched by the stimulus between phases
   int snd_gap_pct   = 6;
   int rcv_stall_pct = 64;
   int hold_count    = 0;

   // size in effect after saturation, used to aim queries
   int eff_w = SOURCE_WIDTH_RST;
   int eff_h = SOURCE_HEIGHT_RST;
   int items_sent = 0;
   bit loaded [int];

   int size_w [PHASES] = '{1, 2, 7, 1024, 0, 5, 2047, 1500, 16};
   int size_h [PHASES] = '{1, 3, 5, 1024, 5, 0, 2047, 9, 16};

   always #5 clock = ~clock;

   masked_bilinear_remap_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   mbr_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   function automatic logic [REQ_DATA_W-1:0] pack_req(input int col, input int row,
                                                      input int pix, input bit lv,
                                                      input int u, input int v,
                                                      input bit en);
      logic [REQ_DATA_W-1:0] d;
      d        = '0;
      d[9:0]   = LOAD_COL_W'(col);
      d[19:10] = LOAD_ROW_W'(row);
      d[27:20] = PIX_W'(pix);
      d[28]    = lv;
      d[47:29] = COORD_W'(u);
      d[66:48] = COORD_W'(v);
      d[67]    = en;
      return d;
   endfunction

   // Pick one coordinate along an axis of n pixels: mostly inside the image,
   // some on the exact edges, some anywhere in the 19-bit range.
   function automatic int pick_coord(input int n);
      logic signed [COORD_W-1:0] raw;
      int r, i, f;
      r = $urandom_range(99);
      if (n == 0 || r < 6) begin
         raw = COORD_W'($urandom);
         return int'(raw);
      end
      if (r < 14) begin
         case ($urandom_range(3))
            0:       return 0;
            1:       return (n - 1) * ONE;
            2:       return (n - 1) * ONE + 1;
            default: return -1;
         endcase
      end
      i = $urandom_range(n - 1);
      if (i == n - 1) f = 0;
      else if ($urandom_range(3) == 0) f = ONE / 2;
      else f = $urandom_range(ONE - 1);
      return i * ONE + f;
   endfunction

   // Offer one request and hold it until the block takes it. Sample tready
   // at the falling edge; inputs only move on rising edges, so it is stable.
   task automatic send_req(input op_type op, input logic [REQ_DATA_W-1:0] data);
      while ($urandom_range(99) < snd_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      items_sent++;
   endtask

   // Load one pixel; the coordinate fields carry noise the block must ignore.
   task automatic load_px(input int col, input int row, input int pix, input bit lv);
      send_req(OP_LOAD, pack_req(col, row, pix, lv, $urandom, $urandom, $urandom_range(1)));
      loaded[row * GRID_COLS + col] = 1'b1;
   endtask

   // Issue one query; the load fields carry noise.
   task automatic query_px(input int u, input int v, input bit en);
      send_req(OP_QUERY, pack_req($urandom_range(1023), $urandom_range(1023),
                                  $urandom_range(255), $urandom_range(1), u, v, en));
   endtask

   // Make sure a store entry was written; now and then overwrite it.
   task automatic touch_px(input int col, input int row);
      if (!loaded.exists(row * GRID_COLS + col) || $urandom_range(99) < 5)
         load_px(col, row, $urandom_range(255), $urandom_range(99) < 88);
   endtask

   // Load every neighbor an in-range query could fetch, past-edge ones
   // included while they lie inside the store, then issue the query.
   task automatic remap_at(input int u, input int v, input bit en);
      int ui, vi;
      if (eff_w > 0 && eff_h > 0 && u >= 0 && v >= 0 &&
          u <= (eff_w - 1) * ONE && v <= (eff_h - 1) * ONE) begin
         ui = u >> FRAC;
         vi = v >> FRAC;
         touch_px(ui, vi);
         if (ui + 1 < GRID_COLS) touch_px(ui + 1, vi);
         if (vi + 1 < GRID_ROWS) touch_px(ui, vi + 1);
         if (ui + 1 < GRID_COLS && vi + 1 < GRID_ROWS) touch_px(ui + 1, vi + 1);
      end
      query_px(u, v, en);
   endtask

   // Drop valid, wait for every response, then let trailing loads retire.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both size registers back to back while the block is idle.
   task automatic set_size(input int w, input int h);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= CSR_SOURCE_WIDTH;
      csr_wdata <= CFG_W'(w);
      @(posedge clock);
      csr_index <= CSR_SOURCE_HEIGHT;
      csr_wdata <= CFG_W'(h);
      @(posedge clock);
      csr_we    <= 1'b0;
      eff_w = (w > GRID_COLS) ? GRID_COLS : w;
      eff_h = (h > GRID_ROWS) ? GRID_ROWS : h;
   endtask

   // Response side: random back-pressure, plus one long hold on request
   // so the pipeline fills and the block has to stall its input.
   initial begin : rsp_side
      int holds_done;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (holds_done < hold_count) begin
            holds_done++;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= rcv_stall_pct);
      end
   end

   // Watchdog: abort when no request or response moves for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      int ph, mode, goal;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset size is 640 x 480: the exact bottom-right corner is in range
      // and uses no neighbor. Load the past-edge ones anyway.
      load_px(639, 479, 200, 1'b1);
      load_px(640, 479, 17, 1'b0);
      load_px(639, 480, 33, 1'b0);
      load_px(640, 480, 99, 1'b0);
      query_px(639 * ONE, 479 * ONE, 1'b1);

      // 2 x 3 image with an invalid past-edge column and row around it;
      // (0,0)=0 and (1,0)=1 give an exact half for rounding, (1,1) is full scale.
      set_size(2, 3);
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (!(c == 2 && r >= 2))
               load_px(c, r,
                       (c == 1 && r == 1) ? 255 : (c == 1 && r == 0) ? 1 : 40 * r + 17 * c,
                       c < 2 && r < 3);
         end
      end
      query_px(ONE / 2, ONE / 2, 1'b0);          // disabled
      query_px(-262144, 0, 1'b1);                // most negative column
      query_px(0, -1, 1'b1);                     // negative row
      query_px(262143, 0, 1'b1);                 // far beyond the last column
      query_px(ONE, ONE / 2, 1'b1);              // last column, right neighbor skipped
      query_px(ONE / 2, 2 * ONE, 1'b1);          // last row, lower neighbors skipped
      query_px(ONE / 2, 0, 1'b1);                // exact half rounds up
      query_px(8'h60, ONE + 8'hA0, 1'b1);        // full four-way weighting
      load_px(0, 2, 77, 1'b0);                   // mask off one neighbor
      query_px(ONE / 2, ONE + ONE / 2, 1'b1);    // touches the masked neighbor

      // Random phases: sweep sizes (zero, one, full and saturating among
      // them) under three idle regimes.
      for (ph = 0; ph < PHASES; ph++) begin
         mode = ph * 3 / PHASES;
         snd_gap_pct   = (mode == 0) ? 6 : (mode == 1) ? 64 : 0;
         rcv_stall_pct = (mode == 0) ? 64 : (mode == 1) ? 6 : 0;
         set_size(size_w[ph], size_h[ph]);
         if (mode == 2 && hold_count == 0) hold_count = 1;
         goal = items_sent + RANDOM_ITEMS / PHASES;
         while (items_sent < goal) begin
            if ($urandom_range(99) < 15) begin
               // stray load: anywhere in the store, or inside the image
               if (eff_w > 0 && eff_h > 0 && $urandom_range(1) == 1)
                  load_px($urandom_range(eff_w - 1), $urandom_range(eff_h - 1),
                          $urandom_range(255), $urandom_range(1));
               else
                  load_px($urandom_range(1023), $urandom_range(1023),
                          $urandom_range(255), $urandom_range(1));
            end else begin
               remap_at(pick_coord(eff_w), pick_coord(eff_h), $urandom_range(99) < 92);
            end
         end
      end

      wait_drained();
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/mbr_pkg.sv
hw/rtl/mbr_ram.sv
hw/rtl/mbr_decode.sv
hw/rtl/mbr_fetch.sv
hw/rtl/mbr_blend.sv
hw/rtl/masked_bilinear_remap_top.sv
tb/mbr_checker.sv
tb/testbench.sv
